// ===== sv/wpa_pkg.sv =====
package wpa_pkg;

  // history and arithmetic sizes
  localparam int unsigned HistDepth = 6;
  localparam int unsigned HistIdxW  = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int unsigned PitchW    = 16;
  localparam int unsigned QFracW    = 40;
  localparam int unsigned AccW      = 64;
  localparam int unsigned DivStepW  = 7;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLowLimit  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHighLimit = 8'd1;

  localparam logic [PitchW-1:0] LowLimitRst  = 16'd880;
  localparam logic [PitchW-1:0] HighLimitRst = 16'd16000;

  typedef struct packed {
    logic [PitchW-1:0] pitch_value;
    logic              last_frame;
  } in_item_t;

  typedef struct packed {
    logic [PitchW-1:0] average_pitch;
    logic              any_voiced;
  } out_item_t;

  // one history slot
  typedef struct packed {
    logic              seen;
    logic [PitchW-1:0] pitch;
  } slot_t;

  // chain control
  typedef struct packed {
    logic clear;
    logic load;
    logic rotate;
  } chain_ctrl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/wpa_cell.sv =====
module wpa_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wpa_pkg::chain_ctrl_t ctrl_i,
  input  wpa_pkg::slot_t       prev_i,
  input  wpa_pkg::slot_t       next_i,
  output wpa_pkg::slot_t       slot_o
);
  import wpa_pkg::*;

  logic              seen_q;
  logic [PitchW-1:0] pitch_q;

  // seen flag: cleared per sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      seen_q <= 1'b0;
    end else if (ctrl_i.load) begin
      seen_q <= prev_i.seen;
    end else if (ctrl_i.rotate) begin
      seen_q <= next_i.seen;
    end
  end

  // pitch payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      pitch_q <= prev_i.pitch;
    end else if (ctrl_i.rotate) begin
      pitch_q <= next_i.pitch;
    end
  end

  assign slot_o = '{seen: seen_q, pitch: pitch_q};

endmodule

// ===== sv/wpa_chain.sv =====
module wpa_chain (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wpa_pkg::chain_ctrl_t       ctrl_i,
  input  logic [wpa_pkg::PitchW-1:0] pitch_i,
  output wpa_pkg::slot_t             head_o
);
  import wpa_pkg::*;

  slot_t slots [HistDepth];
  slot_t new_slot;

  assign new_slot = '{seen: 1'b1, pitch: pitch_i};

  // load shifts toward the tail, rotate moves each slot one step toward the head
  for (genvar k = 0; k < HistDepth; k++) begin : g_cell
    slot_t prev_s;
    slot_t next_s;
    if (k == 0) begin : g_first
      assign prev_s = new_slot;
    end else begin : g_mid
      assign prev_s = slots[k-1];
    end
    if (k == HistDepth - 1) begin : g_last
      assign next_s = slots[0];
    end else begin : g_body
      assign next_s = slots[k+1];
    end
    wpa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .prev_i (prev_s),
      .next_i (next_s),
      .slot_o (slots[k])
    );
  end

  assign head_o = slots[0];

endmodule

// ===== sv/wpa_div.sv =====
module wpa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wpa_pkg::AccW-1:0]     rem_i,
  input  logic [wpa_pkg::AccW-1:0]     bits_i,
  input  logic [wpa_pkg::AccW-1:0]     den_i,
  input  logic [wpa_pkg::DivStepW-1:0] steps_i,
  output wpa_pkg::div_stat_t           stat_o,
  output logic [wpa_pkg::AccW-1:0]     quot_o
);
  import wpa_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [DivStepW-1:0] cnt_q;
  logic [AccW-1:0]     rem_q;
  logic [AccW-1:0]     bits_q;
  logic [AccW-1:0]     den_q;
  logic [AccW-1:0]     quot_q;
  logic [AccW:0]       trial;
  logic                fits;
  logic [AccW:0]       diff;

  // one restoring step per cycle
  assign trial = {rem_q, bits_q[AccW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivStepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      bits_q <= bits_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[AccW-1:0] : trial[AccW-1:0];
      bits_q <= {bits_q[AccW-2:0], 1'b0};
      quot_q <= {quot_q[AccW-2:0], fits};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;

endmodule

// ===== sv/weighted_pitch_average.sv =====
// channel   direction  handshake            payload
// in        input      in_valid_i/in_stall_o    in_item_t (pitch_value, last_frame)
// out       output     out_valid_o/out_stall_i  out_item_t (average_pitch, any_voiced)
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// an unvoiced item only enters the history; a voiced item runs six 41-bit divisions
// on the shared restoring divider plus a split multiply (low, high, sum) per factor
// after the first; a last item with nonzero weight adds the 64-bit average division
// reset clears the history chain and accumulators and loads the reset limits at once, no clearing pass
// one item in flight; in_stall_o is high while it is worked on, and a result left
// in the output register holds back only the next last item

module weighted_pitch_average (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wpa_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wpa_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wpa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wpa_pkg::CfgDataW-1:0] cfg_data_i
);
  import wpa_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FSET  = 11'b00000000010,
    S_RDIV  = 11'b00000000100,
    S_MLO   = 11'b00000001000,
    S_MHI   = 11'b00000010000,
    S_MSUM  = 11'b00000100000,
    S_NEXT  = 11'b00001000000,
    S_ACC   = 11'b00010000000,
    S_ADD   = 11'b00100000000,
    S_SHIFT = 11'b01000000000,
    S_QSET  = 11'b10000000000
  } state_e;

  localparam logic [QFracW-1:0] QOneSat = {QFracW{1'b1}};

  state_e              state_q, state_d;
  logic [PitchW-1:0]   low_q, high_q;
  logic [PitchW-1:0]   v_q;
  logic                last_q;
  logic [HistIdxW-1:0] idx_q;
  logic [QFracW-1:0]   r_q, p_q;
  logic [59:0]         lo_q, hi_q;
  logic [55:0]         prod_q;
  logic [AccW-1:0]     wt_q, wsum_q;
  logic                qdiv_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                in_acc;
  logic                voiced;
  chain_ctrl_t         cctl;
  slot_t               head;
  logic [PitchW-1:0]   pdiff;
  logic [31:0]         dsq;
  logic [19:0]         num;
  logic [32:0]         den;
  logic                div_start;
  logic [AccW-1:0]     div_rem, div_bits, div_den;
  logic [DivStepW-1:0] div_steps;
  div_stat_t           div_st;
  logic [AccW-1:0]     quot;
  logic [QFracW-1:0]   p_sat;
  logic [60:0]         msum;
  logic [AccW:0]       wt_add, wsum_add;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign voiced      = (in_data_i.pitch_value > low_q) && (in_data_i.pitch_value < high_q);

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowLimitRst;
      high_q <= HighLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgLowLimit) begin
        low_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgHighLimit) begin
        high_q <= cfg_data_i;
      end
    end
  end

  // history chain
  assign cctl.load   = (state_q == S_SHIFT);
  assign cctl.rotate = (state_q == S_NEXT);
  assign cctl.clear  = (state_q == S_QSET) && !out_valid_q;

  wpa_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cctl),
    .pitch_i (v_q),
    .head_o  (head)
  );

  // factor operands from the head slot
  assign pdiff = (head.pitch > v_q) ? (head.pitch - v_q) : (v_q - head.pitch);
  assign dsq   = pdiff * pdiff;
  assign num   = head.seen ? {v_q, 4'b0} : 20'd16;
  assign den   = head.seen ? ({13'b0, v_q, 4'b0} + {1'b0, dsq})
                           : (33'd16 + {17'b0, v_q});

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_rem   = {44'b0, 1'b0, num[19:1]};
    div_bits  = {num[0], 63'b0};
    div_den   = {31'b0, den};
    div_steps = DivStepW'(QFracW + 1);
    if (state_q == S_FSET) begin
      div_start = 1'b1;
    end else if (state_q == S_QSET && !out_valid_q && wt_q != '0) begin
      div_start = 1'b1;
      div_rem   = '0;
      div_bits  = wsum_q;
      div_den   = wt_q;
      div_steps = DivStepW'(AccW);
    end
  end

  wpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .bits_i  (div_bits),
    .den_i   (div_den),
    .steps_i (div_steps),
    .stat_o  (div_st),
    .quot_o  (quot)
  );

  assign p_sat = (|quot[AccW-1:QFracW]) ? QOneSat : quot[QFracW-1:0];
  assign msum  = {1'b0, hi_q} + {21'b0, lo_q[59:20]};

  // saturating accumulator sums
  assign wt_add   = {1'b0, wt_q} + {{(AccW-QFracW+1){1'b0}}, r_q};
  assign wsum_add = {1'b0, wsum_q} + {9'b0, prod_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = voiced ? S_FSET : S_SHIFT;
        end
      end
      S_FSET: state_d = S_RDIV;
      S_RDIV: begin
        if (div_st.done) begin
          state_d = (idx_q == '0) ? S_NEXT : S_MLO;
        end
      end
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_MSUM;
      S_MSUM: state_d = S_NEXT;
      S_NEXT: begin
        state_d = (idx_q == HistIdxW'(HistDepth - 1)) ? S_ACC : S_FSET;
      end
      S_ACC:   state_d = S_ADD;
      S_ADD:   state_d = S_SHIFT;
      S_SHIFT: state_d = last_q ? S_QSET : S_IDLE;
      S_QSET: begin
        if (qdiv_q) begin
          if (div_st.done) begin
            state_d = S_IDLE;
          end
        end else if (!out_valid_q && wt_q == '0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      wt_q        <= '0;
      wsum_q      <= '0;
      qdiv_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: idx_q <= '0;
        S_NEXT: begin
          // wraps back to the first slot after the last factor
          idx_q <= (idx_q == HistIdxW'(HistDepth - 1)) ? '0 : idx_q + 1'b1;
        end
        S_ADD: begin
          wt_q   <= wt_add[AccW] ? {AccW{1'b1}} : wt_add[AccW-1:0];
          wsum_q <= wsum_add[AccW] ? {AccW{1'b1}} : wsum_add[AccW-1:0];
        end
        S_QSET: begin
          if (qdiv_q) begin
            if (div_st.done) begin
              qdiv_q      <= 1'b0;
              out_valid_q <= 1'b1;
            end
          end else if (!out_valid_q) begin
            // sequence ends here: clear accumulators, divider holds its operands
            wt_q   <= '0;
            wsum_q <= '0;
            if (wt_q != '0) begin
              qdiv_q <= 1'b1;
            end else begin
              out_valid_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q    <= in_data_i.pitch_value;
      last_q <= in_data_i.last_frame;
    end
    if (state_q == S_RDIV && div_st.done) begin
      p_q <= p_sat;
      if (idx_q == '0) begin
        r_q <= p_sat;
      end
    end
    if (state_q == S_MLO) begin
      lo_q <= r_q * p_q[19:0];
    end
    if (state_q == S_MHI) begin
      hi_q <= r_q * p_q[39:20];
    end
    if (state_q == S_MSUM) begin
      r_q <= msum[59:20];
    end
    if (state_q == S_ACC) begin
      prod_q <= r_q * v_q;
    end
    if (state_q == S_QSET) begin
      if (qdiv_q) begin
        if (div_st.done) begin
          out_q.any_voiced    <= 1'b1;
          out_q.average_pitch <= (|quot[AccW-1:PitchW]) ? {PitchW{1'b1}}
                                                         : quot[PitchW-1:0];
        end
      end else if (!out_valid_q && wt_q == '0) begin
        out_q.any_voiced    <= 1'b0;
        out_q.average_pitch <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_st.busy)
    else $error("divider busy while sequencer idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= HistIdxW'(HistDepth - 1))
    else $error("factor index out of range");

  a_unvoiced_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !voiced) |=> (state_q == S_SHIFT))
    else $error("unvoiced item entered the weight path");

  a_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wt_q == '0) |-> (wsum_q == '0))
    else $error("weighted sum without weight");

endmodule

// ===== tb/sv/weighted_pitch_average_test.sv =====
`timescale 1ns / 100ps

module weighted_pitch_average_test;
  import wpa_pkg::*;

  localparam logic [63:0] Q40Max = (64'd1 << QFracW) - 1;

  // pitch history model and queue of awaited averages
  class pitch_scoreboard;
    logic [PitchW-1:0] low_lim, high_lim;
    logic [PitchW-1:0] hist [HistDepth];
    int unsigned       seen;
    logic [AccW-1:0]   weight_sum, weighted_sum;
    out_item_t         avg_q [$];
    int unsigned       errors;

    function void clear_seq();
      foreach (hist[k]) hist[k] = '0;
      seen = 0;
      weight_sum = '0;
      weighted_sum = '0;
    endfunction

    function void reset_state();
      low_lim = LowLimitRst;
      high_lim = HighLimitRst;
      errors = 0;
      clear_seq();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgLowLimit) low_lim = val;
      else if (idx == CfgHighLimit) high_lim = val;
    endfunction

    function logic [63:0] ratio_q40(logic [63:0] num, logic [63:0] den);
      logic [63:0] r;
      r = (num << QFracW) / den;
      return (r > Q40Max) ? Q40Max : r;
    endfunction

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    // accepted input item: update sums and history, maybe await an average
    function void note_input(in_item_t it);
      logic [63:0]  v, v16, d, p, w;
      logic [127:0] prod;
      out_item_t    res;
      v = it.pitch_value;
      v16 = v * 16;
      w = '0;
      if (it.pitch_value > low_lim && it.pitch_value < high_lim) begin
        for (int j = 0; j < HistDepth; j++) begin
          if (seen > j) begin
            d = (hist[j] > v) ? hist[j] - v : v - hist[j];
            p = ratio_q40(v16, v16 + d * d);
          end else begin
            p = ratio_q40(16, 16 + v);
          end
          if (j == 0) w = p;
          else begin
            prod = 128'(w) * 128'(p);
            w = prod[QFracW +: 64];
          end
        end
        weighted_sum = sat_sum(weighted_sum, w * v);
        weight_sum = sat_sum(weight_sum, w);
      end
      for (int j = HistDepth - 1; j > 0; j--) hist[j] = hist[j-1];
      hist[0] = it.pitch_value;
      if (seen < HistDepth) seen++;
      if (it.last_frame) begin
        if (weight_sum != 0) begin
          d = weighted_sum / weight_sum;
          res.average_pitch = (d > 64'hFFFF) ? 16'hFFFF : d[15:0];
          res.any_voiced = 1'b1;
        end else begin
          res = '0;
        end
        avg_q.push_back(res);
        clear_seq();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (avg_q.size() == 0) begin
        $display("%0t: unexpected average %0d voiced %0b", $time,
                 got.average_pitch, got.any_voiced);
        errors++;
        return;
      end
      want = avg_q.pop_front();
      if (got.average_pitch !== want.average_pitch) begin
        $display("%0t: average_pitch expected %0d actual %0d", $time,
                 want.average_pitch, got.average_pitch);
        errors++;
      end
      if (got.any_voiced !== want.any_voiced) begin
        $display("%0t: any_voiced expected %0b actual %0b", $time,
                 want.any_voiced, got.any_voiced);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return avg_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  pitch_scoreboard sb = new();
  bit          idle_on = 1'b1;
  int unsigned hold_req = 0, hold_seen = 0, hold_left = 0;
  int unsigned items_sent = 0;

  weighted_pitch_average u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls plus a counted long hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 17);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    #30ms;
    $display("weighted_pitch_average test failed");
    $finish;
  end

  task automatic send_frame(logic [PitchW-1:0] pitch, logic last);
    if (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{pitch_value: pitch, last_frame: last};
    do @(posedge clk_i); while (in_stall);
    sb.note_input(in_data);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // valid stays high across back to back writes
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic set_limits(logic [PitchW-1:0] lo, logic [PitchW-1:0] hi);
    drain();
    write_reg(CfgLowLimit, lo);
    write_reg(CfgHighLimit, hi);
    cfg_valid <= 1'b0;
  endtask

  // one sequence around a base pitch, with unvoiced and wild frames mixed in
  task automatic random_sequence(logic [PitchW-1:0] lo, logic [PitchW-1:0] hi);
    int unsigned len, base, roll;
    logic [PitchW-1:0] p;
    len = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
    base = (hi > lo + 2) ? $urandom_range(lo + 1, hi - 1) : $urandom_range(65535);
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(99);
      if (roll < 70) p = 16'(base + $urandom_range(0, 16) - 8);
      else if (roll < 82) p = '0;
      else p = 16'($urandom_range(65535));
      send_frame(p, k == len - 1);
    end
  endtask

  initial begin
    int unsigned lo, hi;
    sb.reset_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: limit edges and field extremes at reset limits
    send_frame(16'd0, 1'b1);
    send_frame(16'd880, 1'b0);
    send_frame(16'd16000, 1'b0);
    send_frame(16'd65535, 1'b1);
    send_frame(16'd881, 1'b0);
    send_frame(16'd15999, 1'b0);
    send_frame(16'd881, 1'b0);
    send_frame(16'd4000, 1'b1);
    send_frame(16'd3520, 1'b0);
    send_frame(16'd3520, 1'b0);
    send_frame(16'd3521, 1'b0);
    send_frame(16'd0, 1'b0);
    send_frame(16'd3519, 1'b0);
    send_frame(16'd3520, 1'b0);
    send_frame(16'd3522, 1'b0);
    send_frame(16'd3520, 1'b1);

    // full range, then crossed and equal limits
    set_limits(16'd0, 16'hFFFF);
    send_frame(16'd1, 1'b0);
    send_frame(16'hFFFE, 1'b1);
    set_limits(16'hFFFF, 16'd0);
    send_frame(16'd5000, 1'b0);
    send_frame(16'd5000, 1'b1);
    set_limits(16'd3000, 16'd3000);
    send_frame(16'd3000, 1'b1);

    // long sequence of steady high pitch, accumulators run large
    set_limits(16'd0, 16'hFFFF);
    idle_on = 1'b0;
    for (int k = 0; k < 300; k++) send_frame(16'hFFFE, k == 299);
    idle_on = 1'b1;

    // receiver holds off while short sequences keep coming
    drain();
    hold_req++;
    for (int k = 0; k < 12; k++) send_frame(16'(2000 + k), k % 3 == 2);

    // random phases over several limit settings
    while (items_sent < 860) begin
      case ($urandom_range(3))
        0: begin lo = LowLimitRst; hi = HighLimitRst; end
        1: begin lo = 0; hi = 65535; end
        2: begin lo = $urandom_range(65535); hi = $urandom_range(65535); end
        default: begin lo = $urandom_range(2000); hi = lo + $urandom_range(50, 6000); end
      endcase
      set_limits(16'(lo), 16'(hi));
      for (int s = 0; s < 10; s++) random_sequence(16'(lo), 16'(hi));
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("weighted_pitch_average test passed");
    else
      $display("weighted_pitch_average test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wpa_pkg.sv
sv/wpa_cell.sv
sv/wpa_chain.sv
sv/wpa_div.sv
sv/weighted_pitch_average.sv
tb/sv/weighted_pitch_average_test.sv
